>>> hdl/line_field_byte_cutter_defines.svh
// ----------------------------------------------------------------------------
// line_field_byte_cutter_defines
// Assertion macros shared by the line cutter modules. A module that uses them
// has ports named i_clk and i_rst_n; checks are off while reset is low.
// ----------------------------------------------------------------------------
`ifndef LINE_FIELD_BYTE_CUTTER_DEFINES_SVH
`define LINE_FIELD_BYTE_CUTTER_DEFINES_SVH

// Same-cycle implication check
`define LFBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfbc: same-cycle check failed");

// Next-cycle implication check
`define LFBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfbc: next-cycle check failed");

`endif

>>> hdl/lfbc_pkg.sv
// ----------------------------------------------------------------------------
// lfbc_pkg
// Constants, codes and controller/datapath interface types of the line cutter.
// ----------------------------------------------------------------------------
package lfbc_pkg;

    // Line store geometry
    localparam int MAX_LINE = 64;
    localparam int ADDR_W   = $clog2(MAX_LINE);
    localparam int LEN_W    = ADDR_W;
    localparam int CUR_W    = $clog2(MAX_LINE + 1);

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_LINE - 1);
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'd0;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd9;

    // Request codes
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIMITER      = 2'd0,
        CFG_FIELD_NUMBER   = 2'd1,
        CFG_START_POSITION = 2'd2,
        CFG_END_POSITION   = 2'd3
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic store;
        logic clear_line;
        logic scan_start;
        logic scan_step;
        logic load_range;
        logic emit_step;
        logic load_lf;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_ends_line;
        logic in_is_data;
        logic field_mode;
        logic scan_done;
        logic rng_none;
        logic emit_done;
        logic out_free;
    } t_dp_status;

endpackage

>>> hdl/line_field_byte_cutter.sv
// ----------------------------------------------------------------------------
// line_field_byte_cutter
// Cuts a field or a byte range out of each text line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per text byte
//   (i_req_type = 0) or an end-of-input request (i_req_type = 1). Output
//   channel (o_out_valid / i_out_stall) carries the selected bytes of a line
//   and then a closing line feed with o_line_done set.
//   Data words are stored at one per cycle while o_in_stall is low; bytes beyond
//   MAX_LINE-1 are dropped. After a line feed or carriage return, or an
//   end-of-input word on a non-empty line, o_in_stall rises until the closing
//   line feed is loaded into the output register, or until a line with too few
//   fields is dropped. Field mode first scans the line content before the
//   selected bytes are read. Output then runs at one word per cycle while the
//   receiver does not stall, set by the single read port of the line store.
//   A receiver stall holds the output register and pauses the store reads.
//   Reset (synchronous, active low) empties the line, restores tab as the
//   delimiter, clears the other control registers and drops any pending output.
//   Configuration writes (i_cfg_wr_en) take effect at once; write only idle.
// ----------------------------------------------------------------------------
module line_field_byte_cutter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [lfbc_pkg::BYTE_W-1:0]         i_in_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lfbc_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_line_done,
    input  logic                                i_cfg_wr_en,
    input  logic [lfbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfbc_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);
    import lfbc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer
    lfbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath
    lfbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_req_type),
        .i_in_byte     (i_in_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_line_done   (o_line_done)
    );

endmodule

>>> hdl/lfbc_ram.sv
// ----------------------------------------------------------------------------
// lfbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/lfbc_ctrl.sv
// ----------------------------------------------------------------------------
// lfbc_ctrl
// Sequencer of the line cutter: collects words, scans for the field, runs the
// emission pass and closes each output line with a line feed.
// ----------------------------------------------------------------------------
module lfbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  lfbc_pkg::t_dp_status  i_status,
    output lfbc_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall
);
    import lfbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RANGE,
        S_EMIT,
        S_CLOSE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_stall;
    logic    n_in_stall;
    t_dp_cmd cmd;
    logic    accept;

    assign accept = i_in_valid && !r_in_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.in_ends_line) begin
                        if (i_status.field_mode) begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end else begin
                            n_state = S_RANGE;
                        end
                    end else if (i_status.in_is_data) begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_status.rng_none) begin
                    cmd.clear_line = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    cmd.load_range = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                cmd.emit_step = 1'b1;
                if (i_status.emit_done) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                cmd.load_lf = 1'b1;
                if (i_status.out_free) begin
                    cmd.clear_line = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    // Hold state and the registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_in_stall;

endmodule

>>> hdl/lfbc_dp.sv
// ----------------------------------------------------------------------------
// lfbc_dp
// Datapath of the line cutter: configuration registers, line store, field
// scan, selection range and the output word register.
// ----------------------------------------------------------------------------
`include "line_field_byte_cutter_defines.svh"

module lfbc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfbc_pkg::t_dp_cmd                   i_cmd,
    output lfbc_pkg::t_dp_status                o_status,
    input  logic                                i_req_type,
    input  logic [lfbc_pkg::BYTE_W-1:0]         i_in_byte,
    input  logic                                i_cfg_wr_en,
    input  logic [lfbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfbc_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lfbc_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_line_done
);
    import lfbc_pkg::*;

    // Configuration
    logic [BYTE_W-1:0] r_delim;
    logic [POS_W-1:0]  r_field_num;
    logic [POS_W-1:0]  r_start_pos;
    logic [POS_W-1:0]  r_end_pos;

    // Line bookkeeping
    logic [LEN_W-1:0]  r_length;
    logic [LEN_W-1:0]  r_content_len;
    logic              r_zero_seen;

    // Read pointer and pending read data
    logic [LEN_W-1:0]  r_ptr;
    logic              r_rd_vld;
    logic [LEN_W-1:0]  r_to;

    // Field scan results
    logic [CUR_W-1:0]  r_cur;
    logic [LEN_W-1:0]  r_begin;
    logic [LEN_W-1:0]  r_fend;
    logic              r_found;

    // Output word register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_line_done;

    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic              out_free;
    logic              scan_issue;
    logic              scan_hit;
    logic              field_match;
    logic              load_out;
    logic              emit_issue;
    logic              lf_load;

    logic [POS_W-1:0]  start_m1;
    logic              end_past;
    logic [LEN_W-1:0]  to_b;
    logic [LEN_W-1:0]  rng_from;
    logic [LEN_W-1:0]  rng_to;
    logic              rng_none;

    // Line store
    lfbc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_length),
        .i_wr_data (i_in_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    // Drop bytes once the store is full
    assign wr_en    = i_cmd.store && (r_length != LEN_MAX);
    assign out_free = !r_out_valid || !i_out_stall;

    // Read sequencing for scan and emission
    always_comb begin
        scan_issue  = i_cmd.scan_step && (r_ptr != r_content_len);
        field_match = (POS_W'(r_cur) == r_field_num);
        scan_hit    = i_cmd.scan_step && r_rd_vld && !r_found && (rd_data == r_delim);
        load_out    = i_cmd.emit_step && r_rd_vld && out_free;
        emit_issue  = i_cmd.emit_step && (r_ptr != r_to) && (!r_rd_vld || load_out);
        rd_en       = scan_issue || emit_issue;
        lf_load     = i_cmd.load_lf && out_free;
    end

    // Selection range for the current mode
    always_comb begin
        start_m1 = r_start_pos - POS_W'(1);
        end_past = (r_end_pos == '0) || (r_end_pos > POS_W'(r_content_len));
        to_b     = end_past ? r_content_len : r_end_pos[LEN_W-1:0];
        rng_from = '0;
        rng_to   = r_content_len;
        rng_none = 1'b0;
        if (r_field_num != '0) begin
            if (r_found) begin
                rng_from = r_begin;
                rng_to   = r_fend;
            end else if (field_match) begin
                rng_from = r_begin;
            end else if (r_cur != CUR_W'(1)) begin
                rng_none = 1'b1;
            end
        end else if (r_start_pos != '0) begin
            if (start_m1 >= POS_W'(to_b)) begin
                rng_to = '0;
            end else begin
                rng_from = start_m1[LEN_W-1:0];
                rng_to   = to_b;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_status              = '0;
        o_status.in_is_data   = (i_req_type == REQ_DATA);
        o_status.in_ends_line = (i_req_type == REQ_EOF) ? (r_length != '0)
                                : ((i_in_byte == CHAR_LF) || (i_in_byte == CHAR_CR));
        o_status.field_mode   = (r_field_num != '0);
        o_status.scan_done    = (r_ptr == r_content_len) && !r_rd_vld;
        o_status.rng_none     = rng_none;
        o_status.emit_done    = (r_ptr == r_to) && !r_rd_vld;
        o_status.out_free     = out_free;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim       <= DELIM_RESET;
            r_field_num   <= '0;
            r_start_pos   <= '0;
            r_end_pos     <= '0;
            r_length      <= '0;
            r_content_len <= '0;
            r_zero_seen   <= 1'b0;
            r_ptr         <= '0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Write configuration
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_DELIMITER:      r_delim     <= i_cfg_wr_data[BYTE_W-1:0];
                    CFG_FIELD_NUMBER:   r_field_num <= i_cfg_wr_data[POS_W-1:0];
                    CFG_START_POSITION: r_start_pos <= i_cfg_wr_data[POS_W-1:0];
                    CFG_END_POSITION:   r_end_pos   <= i_cfg_wr_data[POS_W-1:0];
                    default:            r_delim     <= r_delim;
                endcase
            end

            // Append a word, track content up to the first zero byte
            if (wr_en) begin
                r_length <= r_length + LEN_W'(1);
                if (!r_zero_seen) begin
                    if (i_in_byte == CHAR_NUL) begin
                        r_zero_seen <= 1'b1;
                    end else begin
                        r_content_len <= r_length + LEN_W'(1);
                    end
                end
            end else if (i_cmd.clear_line) begin
                r_length      <= '0;
                r_content_len <= '0;
                r_zero_seen   <= 1'b0;
            end

            // Advance the read pointer
            if (i_cmd.scan_start) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.load_range) begin
                r_ptr    <= rng_from;
                r_rd_vld <= 1'b0;
            end else if (rd_en) begin
                r_ptr    <= r_ptr + LEN_W'(1);
                r_rd_vld <= 1'b1;
            end else if (i_cmd.scan_step || load_out) begin
                r_rd_vld <= 1'b0;
            end

            if (scan_hit && field_match) begin
                r_found <= 1'b1;
            end

            // Output word register
            if (load_out || lf_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_cur   <= CUR_W'(1);
            r_begin <= '0;
        end else if (scan_hit && !field_match) begin
            r_cur   <= r_cur + CUR_W'(1);
            r_begin <= r_ptr;
        end
        if (scan_hit && field_match) begin
            r_fend <= r_ptr - LEN_W'(1);
        end
        if (i_cmd.load_range) begin
            r_to <= rng_to;
        end
        if (load_out) begin
            r_out_byte  <= rd_data;
            r_line_done <= 1'b0;
        end else if (lf_load) begin
            r_out_byte  <= CHAR_LF;
            r_line_done <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_line_done = r_line_done;

    // Checks
    `LFBC_ASSERT_IMP(a_len_bound, 1'b1, r_length <= LEN_MAX)
    `LFBC_ASSERT_IMP(a_content_le_len, 1'b1, r_content_len <= r_length)
    `LFBC_ASSERT_IMP(a_close_is_lf, r_out_valid && r_line_done, r_out_byte == CHAR_LF)
    `LFBC_ASSERT_NEXT(a_store_grows, wr_en, r_length == $past(r_length) + LEN_W'(1))

endmodule

>>> test/line_field_byte_cutter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_field_byte_cutter_tb
// Self-checking bench for the line cutter. A queue of text words feeds a
// bursty driver, a stalling receiver drains the output, and a line-level
// predictor of field, byte-range and whole-line cuts checks every output word.
// Each phase after the first programs a new cut setting while the block is idle.
// ----------------------------------------------------------------------------
module line_field_byte_cutter_tb;
    import lfbc_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLDOFF_EVERY = 2500;
    localparam int HOLDOFF_LEN   = 400;

    typedef struct packed {
        logic              req;
        logic [BYTE_W-1:0] data;
    } t_text_word;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              done;
    } t_cut_word;

    // DUT connections, all inputs known from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  req_type    = REQ_DATA;
    logic [BYTE_W-1:0]     in_data     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [BYTE_W-1:0]     out_data;
    logic                  line_done;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Stimulus and cut predictions
    t_text_word  text_words_q[$];
    t_cut_word   cut_words_q[$];
    t_text_word  next_word;
    t_cut_word   due_word;
    int unsigned words_queued = 0;
    int unsigned failures     = 0;
    int unsigned cycle_count  = 0;
    logic        word_taken   = 1'b0;

    // Predictor copy of the line and of the cut setting
    logic [BYTE_W-1:0] line_buf [MAX_LINE];
    int unsigned       line_len   = 0;
    logic [BYTE_W-1:0] delim_cfg  = DELIM_RESET;
    logic [POS_W-1:0]  field_sel  = '0;
    logic [POS_W-1:0]  first_pos  = '0;
    logic [POS_W-1:0]  last_pos   = '0;

    // Sender and receiver pacing
    int unsigned burst_left   = 4;
    int unsigned gap_left     = 0;
    int unsigned rx_cycle     = 0;
    int unsigned rx_mode      = 0;
    int unsigned holdoff_left = 0;
    int unsigned holdoff_due  = 300;

    line_field_byte_cutter i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_in_byte    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_data),
        .o_line_done  (line_done),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cut predictor
    // ------------------------------------------------------------------
    task automatic push_cut(logic [BYTE_W-1:0] data, logic done);
        cut_words_q.push_back('{data: data, done: done});
    endtask

    task automatic emit_span(int unsigned from, int unsigned upto);
        for (int unsigned k = from; k < upto && k < MAX_LINE; k++)
            push_cut(line_buf[k], 1'b0);
    endtask

    // Work out the words of one finished line
    task automatic cut_line();
        int unsigned len;
        int unsigned field_idx;
        int unsigned field_start;
        int unsigned i;
        len = 0;
        // content stops at the first NUL
        while (len < line_len && line_buf[len] != CHAR_NUL)
            len++;
        if (field_sel != 0) begin
            field_idx   = 1;
            field_start = 0;
            for (i = 0; i < len; i++) begin
                if (line_buf[i] == delim_cfg) begin
                    if (field_idx == field_sel) begin
                        emit_span(field_start, i);
                        push_cut(CHAR_LF, 1'b1);
                        return;
                    end
                    field_idx++;
                    field_start = i + 1;
                end
            end
            if (field_idx == field_sel) begin
                emit_span(field_start, len);
                push_cut(CHAR_LF, 1'b1);
            end else if (field_idx == 1) begin
                // no delimiter at all: pass the line whole
                emit_span(0, len);
                push_cut(CHAR_LF, 1'b1);
            end
            // too few fields: drop the line, LF included
            return;
        end
        if (first_pos != 0) begin
            for (i = 1; i <= len; i++) begin
                if (i >= first_pos && (last_pos == 0 || i <= last_pos))
                    push_cut(line_buf[i - 1], 1'b0);
            end
        end else begin
            emit_span(0, len);
        end
        push_cut(CHAR_LF, 1'b1);
    endtask

    // Advance the predictor by one accepted word
    task automatic absorb_word(logic req, logic [BYTE_W-1:0] data);
        if (req == REQ_EOF) begin
            if (line_len != 0) begin
                cut_line();
                line_len = 0;
            end
        end else if (data == CHAR_LF || data == CHAR_CR) begin
            cut_line();
            line_len = 0;
        end else if (line_len < MAX_LINE - 1) begin
            line_buf[line_len] = data;
            line_len++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(logic req, logic [BYTE_W-1:0] data);
        text_words_q.push_back('{req: req, data: data});
        words_queued++;
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++)
            push_word(REQ_DATA, s[k]);
    endtask

    function automatic logic [BYTE_W-1:0] content_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return delim_cfg;
        if (pick < 23)
            return CHAR_NUL;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed lines, some long ones, plus stray words
    task automatic push_random_text(int unsigned n_words);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        stop_at = words_queued + n_words;
        while (words_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len = ($urandom_range(0, 99) < 10) ? $urandom_range(60, 80)
                                                    : $urandom_range(0, 12);
                repeat (len) push_word(REQ_DATA, content_byte());
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    push_word(REQ_DATA, CHAR_LF);
                else if (pick < 80)
                    push_word(REQ_DATA, CHAR_CR);
                else
                    push_word(REQ_EOF, BYTE_W'($urandom));
            end else if (pick < 93) begin
                push_word(REQ_EOF, BYTE_W'($urandom));
            end else begin
                push_word(REQ_DATA, BYTE_W'($urandom));
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_DELIMITER:      delim_cfg = BYTE_W'(value);
            CFG_FIELD_NUMBER:   field_sel = POS_W'(value);
            CFG_START_POSITION: first_pos = POS_W'(value);
            CFG_END_POSITION:   last_pos  = POS_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_cut(int unsigned delim, int unsigned field,
                           int unsigned first, int unsigned last);
        write_reg(CFG_DELIMITER, delim);
        write_reg(CFG_FIELD_NUMBER, field);
        write_reg(CFG_START_POSITION, first);
        write_reg(CFG_END_POSITION, last);
    endtask

    // Wait for all words sent and all cuts seen, then let a field scan finish
    task automatic drain();
        while (text_words_q.size() != 0 || in_valid || cut_words_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps, hold while stalled
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && !word_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (text_words_q.size() != 0) begin
                next_word = text_words_q.pop_front();
                req_type <= next_word.req;
                in_data  <= next_word.data;
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern by mode, plus a long hold-off while output
    // is pending and the sender still has words queued
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        rx_cycle++;
        if (rx_cycle % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (holdoff_left != 0) begin
            holdoff_left--;
            out_stall <= 1'b1;
        end else if (rx_cycle >= holdoff_due && out_valid && text_words_q.size() >= 8) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_due  = rx_cycle + HOLDOFF_EVERY;
            out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_cycle[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check output words, then fold accepted input into the line
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                if (cut_words_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected word: expected none, actual byte %h done %b",
                             $time, out_data, line_done);
                end else begin
                    due_word = cut_words_q.pop_front();
                    if (out_data !== due_word.data) begin
                        failures++;
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, due_word.data, out_data);
                    end
                    if (line_done !== due_word.done) begin
                        failures++;
                        $display("%0t: line_done mismatch: expected %b, actual %b",
                                 $time, due_word.done, line_done);
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_word(req_type, in_data);
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Whole-line mode at reset values
        push_word(REQ_EOF, 8'hFF);          // empty store: nothing
        push_text("AB");
        push_word(REQ_DATA, CHAR_LF);
        push_word(REQ_DATA, CHAR_CR);       // empty line: LF only
        push_word(REQ_DATA, "x");
        push_word(REQ_DATA, CHAR_NUL);      // NUL cuts the content
        push_word(REQ_DATA, "y");
        push_word(REQ_DATA, CHAR_LF);
        push_word(REQ_DATA, 8'hFF);
        push_word(REQ_DATA, 8'h01);
        push_word(REQ_DATA, 8'h80);
        push_word(REQ_EOF, 8'h00);          // flush partial line
        push_word(REQ_EOF, 8'h55);
        push_random_text(20);
        drain();

        // Second comma field, and a line without delimiter
        set_cut(",", 2, 0, 0);
        push_text("a,b,c");
        push_word(REQ_DATA, CHAR_LF);
        push_text("ab");
        push_word(REQ_DATA, CHAR_CR);
        push_random_text(20);
        drain();

        // Field far beyond the line count: lines with delimiters vanish
        set_cut(8'hFF, 1023, 0, 0);
        push_word(REQ_DATA, "a");
        push_word(REQ_DATA, 8'hFF);
        push_word(REQ_DATA, "b");
        push_word(REQ_DATA, CHAR_LF);
        push_random_text(20);
        drain();

        // NUL delimiter never matches
        set_cut(0, 1, 0, 0);
        push_random_text(20);
        drain();

        // Byte modes: open end, middle range, beyond the line, empty range
        set_cut(DELIM_RESET, 0, 1, 0);
        push_random_text(20);
        drain();
        set_cut(DELIM_RESET, 0, 3, 5);
        push_random_text(20);
        drain();
        set_cut(DELIM_RESET, 0, 1023, 1023);
        push_random_text(20);
        drain();
        set_cut(DELIM_RESET, 0, 5, 2);
        push_random_text(20);
        drain();

        // Field mode overrides a byte range
        set_cut(" ", 3, 2, 0);
        push_random_text(20);
        drain();

        // Random settings
        repeat (4) begin
            set_cut(($urandom_range(0, 3) == 0) ? 0 :
                    ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 255),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4),
                    ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 8),
                    $urandom_range(0, 10));
            push_random_text(20);
            drain();
        end

        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
